### src/rptw_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types for the
// radix page table block. No dependencies.
package rptw_pkg;

   // table geometry and field widths
   localparam int MAX_PAGES  = 4096;
   localparam int IDX_W      = 12;
   localparam int FRAME_W    = 36;
   localparam int VA_W       = 48;
   localparam int PAGE_W     = 13;
   localparam int OP_W       = 2;
   localparam int LEAF_W     = FRAME_W + 2;
   localparam int MAX_LEVELS = 4;
   localparam int MAX_LBITS  = 12;

   // configuration register widths
   localparam int SHIFT_W    = 5;
   localparam int LBITS_W    = 4;
   localparam int LCOUNT_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // operation codes
   localparam logic [OP_W-1:0] OP_MAP    = 2'd0;
   localparam logic [OP_W-1:0] OP_ACCESS = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT  = 2'd3;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic capture;
      logic decode;
      logic read;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } status_type;

endpackage

### src/radix_page_table_map_and_walk.sv
`timescale 1ns / 1ps
// Top level of the radix page table: sequencer plus datapath.
// Depends on rptw_pkg, rptw_ctrl and rptw_datapath.
//
// Usage:
//   Request channel (req_*): valid/stall. Each beat carries an operation
//   (map, access by virtual address, lookup by page number) and its fields.
//   Response channel (rsp_*): valid/stall, exactly one beat per request.
//   Configuration (csr_*): write enable, index and data; write only while
//   the block is idle. Indexes: 0 page shift, 1 level bits, 2 level count,
//   3 page count.
// Timing:
//   A request is taken in the idle state, decoded (address shift and index
//   split), the tables are read (registered RAM data), and the result goes
//   to the output register with any map write in that same cycle. Response
//   valid rises after the decode, read and finish states; a new request is
//   taken only once the one-at-a-time sequence is back in idle.
// Reset:
//   A clearing sweep zeroes all 4096 table entries while req_stall is held
//   high; configuration writes are taken throughout.
// Stall:
//   A result waits in the output register while rsp_stall is high and the
//   sequencer holds in its finish state until the register frees.
module radix_page_table_map_and_walk (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_write_enable,
   input  logic [rptw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rptw_pkg::CSR_DATA_W-1:0]     csr_write_data,
   // requests
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rptw_pkg::OP_W-1:0]           req_operation,
   input  logic [rptw_pkg::VA_W-1:0]           req_vaddr,
   input  logic [rptw_pkg::PAGE_W-1:0]         req_page,
   input  logic [rptw_pkg::FRAME_W-1:0]        req_frame,
   input  logic                                req_in_ram,
   // responses
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_range_error,
   output logic                                rsp_path_valid,
   output logic                                rsp_page_mapped,
   output logic                                rsp_entry_in_ram,
   output logic [rptw_pkg::FRAME_W-1:0]        rsp_entry_frame,
   output logic                                rsp_fault
);

   rptw_pkg::cmd_type    cmd;
   rptw_pkg::status_type status;

   // sequencer
   rptw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // tables and result path
   rptw_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_operation       (req_operation),
      .req_vaddr           (req_vaddr),
      .req_page            (req_page),
      .req_frame           (req_frame),
      .req_in_ram          (req_in_ram),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_range_error     (rsp_range_error),
      .rsp_path_valid      (rsp_path_valid),
      .rsp_page_mapped     (rsp_page_mapped),
      .rsp_entry_in_ram    (rsp_entry_in_ram),
      .rsp_entry_frame     (rsp_entry_frame),
      .rsp_fault           (rsp_fault)
   );

endmodule

### src/rptw_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the radix page table: clearing sweep, then one item at a
// time through decode, table read and finish. Uses rptw_pkg.
module rptw_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rptw_pkg::status_type status,
   output rptw_pkg::cmd_type    cmd
);

   rptw_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rptw_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rptw_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = rptw_pkg::ST_IDLE;
         end
         rptw_pkg::ST_IDLE: begin
            if (req_valid) state_in = rptw_pkg::ST_DECODE;
         end
         rptw_pkg::ST_DECODE: begin
            state_in = rptw_pkg::ST_READ;
         end
         rptw_pkg::ST_READ: begin
            state_in = rptw_pkg::ST_FINISH;
         end
         rptw_pkg::ST_FINISH: begin
            if (status.out_free) state_in = rptw_pkg::ST_IDLE;
         end
         default: begin
            state_in = rptw_pkg::ST_CLEAR;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      req_stall   = 1'b1;
      unique case (state_ff)
         rptw_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         rptw_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         rptw_pkg::ST_DECODE: begin
            cmd.decode = 1'b1;
         end
         rptw_pkg::ST_READ: begin
            cmd.read = 1'b1;
         end
         rptw_pkg::ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### src/rptw_datapath.sv
`timescale 1ns / 1ps
// Datapath for the radix page table: configuration registers, index split,
// leaf and level-valid tables, and the result register. Uses rptw_pkg.
module rptw_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rptw_pkg::cmd_type                   cmd,
   output rptw_pkg::status_type                status,
   // configuration
   input  logic                                csr_write_enable,
   input  logic [rptw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rptw_pkg::CSR_DATA_W-1:0]     csr_write_data,
   // request payload
   input  logic [rptw_pkg::OP_W-1:0]           req_operation,
   input  logic [rptw_pkg::VA_W-1:0]           req_vaddr,
   input  logic [rptw_pkg::PAGE_W-1:0]         req_page,
   input  logic [rptw_pkg::FRAME_W-1:0]        req_frame,
   input  logic                                req_in_ram,
   // response
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_range_error,
   output logic                                rsp_path_valid,
   output logic                                rsp_page_mapped,
   output logic                                rsp_entry_in_ram,
   output logic [rptw_pkg::FRAME_W-1:0]        rsp_entry_frame,
   output logic                                rsp_fault
);

   localparam int IDX_W = rptw_pkg::IDX_W;

   // mask of the low n bits of a table index
   function automatic logic [IDX_W-1:0] low_mask(input logic [5:0] n);
      logic [IDX_W-1:0] m;
      if (n >= 6'(IDX_W)) begin
         m = '1;
      end else begin
         m = (IDX_W'(1) << n) - IDX_W'(1);
      end
      return m;
   endfunction

   // ---------------------------------------------------------------
   // configuration registers
   logic [rptw_pkg::SHIFT_W-1:0]  page_shift_ff;
   logic [rptw_pkg::LBITS_W-1:0]  level_bits_ff;
   logic [rptw_pkg::LCOUNT_W-1:0] level_count_ff;
   logic [rptw_pkg::PAGE_W-1:0]   page_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff  <= 5'd12;
         level_bits_ff  <= 4'd9;
         level_count_ff <= 3'd2;
         page_count_ff  <= 13'(rptw_pkg::MAX_PAGES);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            rptw_pkg::CSR_PAGE_SHIFT:  page_shift_ff  <= csr_write_data[4:0];
            rptw_pkg::CSR_LEVEL_BITS:  level_bits_ff  <= csr_write_data[3:0];
            rptw_pkg::CSR_LEVEL_COUNT: level_count_ff <= csr_write_data[2:0];
            rptw_pkg::CSR_PAGE_COUNT:  page_count_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // saturated geometry
   logic [2:0]                  levels;
   logic [3:0]                  lbits;
   logic [rptw_pkg::PAGE_W-1:0] limit;

   always_comb begin
      if (level_count_ff == 3'd0) begin
         levels = 3'd1;
      end else if (level_count_ff > 3'(rptw_pkg::MAX_LEVELS)) begin
         levels = 3'(rptw_pkg::MAX_LEVELS);
      end else begin
         levels = level_count_ff;
      end
      if (level_bits_ff == 4'd0) begin
         lbits = 4'd1;
      end else if (level_bits_ff > 4'(rptw_pkg::MAX_LBITS)) begin
         lbits = 4'(rptw_pkg::MAX_LBITS);
      end else begin
         lbits = level_bits_ff;
      end
      if (page_count_ff > 13'(rptw_pkg::MAX_PAGES)) begin
         limit = 13'(rptw_pkg::MAX_PAGES);
      end else begin
         limit = page_count_ff;
      end
   end

   // ---------------------------------------------------------------
   // capture the request beat
   logic [rptw_pkg::OP_W-1:0]    op_ff;
   logic [rptw_pkg::VA_W-1:0]    va_ff;
   logic [rptw_pkg::PAGE_W-1:0]  page_ff;
   logic [rptw_pkg::FRAME_W-1:0] frame_ff;
   logic                         ram_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         va_ff    <= req_vaddr;
         page_ff  <= req_page;
         frame_ff <= req_frame;
         ram_ff   <= req_in_ram;
      end
   end

   // ---------------------------------------------------------------
   // decode: zero-based page index, range check, per-level indices
   logic [rptw_pkg::VA_W-1:0]   vpn;
   logic [rptw_pkg::PAGE_W-1:0] page_m1;
   logic [IDX_W-1:0]            v_idx;
   logic                        in_range;
   logic [2:0]                  lm1, lm2, lm3;
   logic [5:0]                  sh1, sh2, sh3, leaf_bits;
   logic [IDX_W-1:0]            leaf_idx, k1_idx, k2_idx, k3_idx;

   always_comb begin
      vpn     = va_ff >> page_shift_ff;
      page_m1 = page_ff - 13'd1;
      if (op_ff == rptw_pkg::OP_ACCESS) begin
         in_range = vpn < rptw_pkg::VA_W'(limit);
         v_idx    = vpn[IDX_W-1:0];
      end else begin
         in_range = (page_ff != 13'd0) && (page_ff <= limit);
         v_idx    = page_m1[IDX_W-1:0];
      end
      lm1       = levels - 3'd1;
      lm2       = levels - 3'd2;
      lm3       = levels - 3'd3;
      sh1       = 6'({3'b0, lm1} * {2'b0, lbits});
      sh2       = 6'({3'b0, lm2} * {2'b0, lbits});
      sh3       = 6'({3'b0, lm3} * {2'b0, lbits});
      leaf_bits = 6'({3'b0, levels} * {2'b0, lbits});
      k1_idx    = '0;
      k2_idx    = '0;
      k3_idx    = '0;
      if (levels == 3'd1) begin
         leaf_idx = v_idx;
      end else begin
         leaf_idx = v_idx & low_mask(leaf_bits);
         k1_idx   = (v_idx >> sh1) & low_mask({2'b0, lbits});
      end
      if (levels >= 3'd3) begin
         k2_idx = (v_idx >> sh2) & low_mask({1'b0, lbits, 1'b0});
      end
      if (levels == 3'd4) begin
         k3_idx = (v_idx >> sh3) & low_mask(6'({2'b0, lbits} * 6'd3));
      end
   end

   logic             in_range_ff;
   logic [IDX_W-1:0] leaf_ff, k1_ff, k2_ff, k3_ff;

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         in_range_ff <= in_range;
         leaf_ff     <= leaf_idx;
         k1_ff       <= k1_idx;
         k2_ff       <= k2_idx;
         k3_ff       <= k3_idx;
      end
   end

   // ---------------------------------------------------------------
   // clearing sweep address
   logic [IDX_W-1:0] clear_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else if (cmd.clear) begin
         clear_addr_ff <= clear_addr_ff + IDX_W'(1);
      end
   end

   // ---------------------------------------------------------------
   // table write controls
   logic                        map_write;
   logic                        leaf_we, top_we, sec_we, third_we;
   logic [IDX_W-1:0]            leaf_wa, top_wa, sec_wa, third_wa;
   logic [rptw_pkg::LEAF_W-1:0] leaf_wd;
   logic                        mark_wd;

   always_comb begin
      map_write = cmd.finish && (op_ff == rptw_pkg::OP_MAP) && in_range_ff;
      leaf_we   = cmd.clear || map_write;
      top_we    = cmd.clear || (map_write && (levels >= 3'd2));
      sec_we    = cmd.clear || (map_write && (levels >= 3'd3));
      third_we  = cmd.clear || (map_write && (levels == 3'd4));
      leaf_wa   = cmd.clear ? clear_addr_ff : leaf_ff;
      top_wa    = cmd.clear ? clear_addr_ff : k1_ff;
      sec_wa    = cmd.clear ? clear_addr_ff : k2_ff;
      third_wa  = cmd.clear ? clear_addr_ff : k3_ff;
      leaf_wd   = cmd.clear ? '0 : {1'b1, ram_ff, frame_ff};
      mark_wd   = !cmd.clear;
   end

   // ---------------------------------------------------------------
   // leaf table: {mapped, in_ram, frame}
   logic [rptw_pkg::LEAF_W-1:0] leaf_mem [rptw_pkg::MAX_PAGES];
   logic [rptw_pkg::LEAF_W-1:0] leaf_rd_ff;

   always_ff @(posedge clock) begin
      if (leaf_we) leaf_mem[leaf_wa] <= leaf_wd;
      if (cmd.read) leaf_rd_ff <= leaf_mem[leaf_ff];
   end

   // level valid marks
   logic top_mem   [rptw_pkg::MAX_PAGES];
   logic sec_mem   [rptw_pkg::MAX_PAGES];
   logic third_mem [rptw_pkg::MAX_PAGES];
   logic top_rd_ff, sec_rd_ff, third_rd_ff;

   always_ff @(posedge clock) begin
      if (top_we) top_mem[top_wa] <= mark_wd;
      if (cmd.read) top_rd_ff <= top_mem[k1_ff];
   end

   always_ff @(posedge clock) begin
      if (sec_we) sec_mem[sec_wa] <= mark_wd;
      if (cmd.read) sec_rd_ff <= sec_mem[k2_ff];
   end

   always_ff @(posedge clock) begin
      if (third_we) third_mem[third_wa] <= mark_wd;
      if (cmd.read) third_rd_ff <= third_mem[k3_ff];
   end

   // ---------------------------------------------------------------
   // result of the walk
   logic                         res_range_error, res_path_valid, res_mapped;
   logic                         res_in_ram, res_fault, walk_ok;
   logic [rptw_pkg::FRAME_W-1:0] res_frame;

   always_comb begin
      res_range_error = 1'b0;
      res_path_valid  = 1'b0;
      res_mapped      = 1'b0;
      res_in_ram      = 1'b0;
      res_frame       = '0;
      res_fault       = 1'b0;
      walk_ok = ((levels < 3'd2) || top_rd_ff) &&
                ((levels < 3'd3) || sec_rd_ff) &&
                ((levels < 3'd4) || third_rd_ff);
      unique case (op_ff)
         rptw_pkg::OP_MAP: begin
            // after the write the whole path is marked
            if (!in_range_ff) begin
               res_range_error = 1'b1;
            end else begin
               res_path_valid = 1'b1;
               res_mapped     = 1'b1;
               res_in_ram     = ram_ff;
               res_frame      = frame_ff;
               res_fault      = !ram_ff;
            end
         end
         rptw_pkg::OP_ACCESS, rptw_pkg::OP_LOOKUP: begin
            if (!in_range_ff) begin
               res_range_error = 1'b1;
            end else if (walk_ok) begin
               res_path_valid = 1'b1;
               res_mapped     = leaf_rd_ff[rptw_pkg::LEAF_W-1];
               res_in_ram     = leaf_rd_ff[rptw_pkg::FRAME_W];
               res_frame      = leaf_rd_ff[rptw_pkg::FRAME_W-1:0];
               res_fault      = !leaf_rd_ff[rptw_pkg::FRAME_W];
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------
   // response register
   logic                         rsp_valid_ff;
   logic                         range_error_ff, path_valid_ff, mapped_ff;
   logic                         entry_in_ram_ff, fault_ff;
   logic [rptw_pkg::FRAME_W-1:0] entry_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         range_error_ff  <= res_range_error;
         path_valid_ff   <= res_path_valid;
         mapped_ff       <= res_mapped;
         entry_in_ram_ff <= res_in_ram;
         entry_frame_ff  <= res_frame;
         fault_ff        <= res_fault;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_range_error  = range_error_ff;
   assign rsp_path_valid   = path_valid_ff;
   assign rsp_page_mapped  = mapped_ff;
   assign rsp_entry_in_ram = entry_in_ram_ff;
   assign rsp_entry_frame  = entry_frame_ff;
   assign rsp_fault        = fault_ff;

   // status back to the sequencer
   assign status.clear_last = &clear_addr_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

### tb/tb_radix_page_table_map_and_walk.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix_page_table_map_and_walk: directed and random
// map/access/lookup beats over several table geometries, checked against a local table.
// Depends on rptw_pkg and the radix_page_table_map_and_walk RTL.
module tb_radix_page_table_map_and_walk;
   import rptw_pkg::*;

   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
   localparam int QUIET_LIMIT = 30000;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [VA_W-1:0]    vaddr;
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
      logic               in_ram;
   } walk_req_type;

   typedef struct packed {
      logic               range_error;
      logic               path_valid;
      logic               page_mapped;
      logic               entry_in_ram;
      logic [FRAME_W-1:0] entry_frame;
      logic               fault;
   } walk_rsp_type;

   logic clock;
   logic reset = 1'b1;

   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [OP_W-1:0]    req_operation = '0;
   logic [VA_W-1:0]    req_vaddr = '0;
   logic [PAGE_W-1:0]  req_page = '0;
   logic [FRAME_W-1:0] req_frame = '0;
   logic               req_in_ram = 1'b0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_range_error;
   logic               rsp_path_valid;
   logic               rsp_page_mapped;
   logic               rsp_entry_in_ram;
   logic [FRAME_W-1:0] rsp_entry_frame;
   logic               rsp_fault;

   // local copy of the table, cleared like the block's after reset
   bit [FRAME_W-1:0] leaf_frames   [MAX_PAGES];
   bit               leaf_in_ram   [MAX_PAGES];
   bit               leaf_mapped   [MAX_PAGES];
   bit               top_valid     [MAX_PAGES];
   bit               second_valid  [MAX_PAGES];
   bit               third_valid   [MAX_PAGES];

   // local copy of the registers
   logic [SHIFT_W-1:0]  cfg_page_shift  = 5'd12;
   logic [LBITS_W-1:0]  cfg_level_bits  = 4'd9;
   logic [LCOUNT_W-1:0] cfg_level_count = 3'd2;
   logic [PAGE_W-1:0]   cfg_page_count  = 13'd4096;

   walk_req_type      pending_reqs[$];
   walk_rsp_type      expected_walks[$];
   logic [PAGE_W-1:0] hot_pages[$];
   walk_req_type      offered_beat;

   int req_gap_max = 0;
   int rsp_gap_max = 0;
   int req_wait_left = 0;
   int rsp_wait_left = 0;
   int rsp_hold_left = 0;
   int results_seen = 0;
   int quiet_cycles = 0;
   int mismatches = 0;

   radix_page_table_map_and_walk DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_vaddr           (req_vaddr),
      .req_page            (req_page),
      .req_frame           (req_frame),
      .req_in_ram          (req_in_ram),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_range_error     (rsp_range_error),
      .rsp_path_valid      (rsp_path_valid),
      .rsp_page_mapped     (rsp_page_mapped),
      .rsp_entry_in_ram    (rsp_entry_in_ram),
      .rsp_entry_frame     (rsp_entry_frame),
      .rsp_fault           (rsp_fault)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // level count saturates to 1..4
   function automatic int levels_in_use();
      int l;
      l = cfg_level_count;
      if (l < 1) l = 1;
      if (l > MAX_LEVELS) l = MAX_LEVELS;
      return l;
   endfunction

   function automatic int page_limit();
      return (cfg_page_count > MAX_PAGES) ? MAX_PAGES : int'(cfg_page_count);
   endfunction

   function automatic bit page_in_range(input logic [63:0] page);
      return (page >= 64'd1) && (page <= 64'(page_limit()));
   endfunction

   // break a zero-based page index into leaf position and upper-level keys
   function automatic void split_index(input logic [63:0] v, output logic [63:0] leaf,
                                       output logic [63:0] k1, output logic [63:0] k2,
                                       output logic [63:0] k3);
      int l;
      int b;
      l = levels_in_use();
      b = cfg_level_bits;
      if (b < 1) b = 1;
      if (b > MAX_LBITS) b = MAX_LBITS;
      k1 = '0;
      k2 = '0;
      k3 = '0;
      if (l == 1) begin
         leaf = v;
      end else begin
         leaf = v & ((64'd1 << (l * b)) - 64'd1);
         k1 = (v >> ((l - 1) * b)) & ((64'd1 << b) - 64'd1);
         if (l >= 3) k2 = (v >> ((l - 2) * b)) & ((64'd1 << (2 * b)) - 64'd1);
         if (l == 4) k3 = (v >> ((l - 3) * b)) & ((64'd1 << (3 * b)) - 64'd1);
      end
   endfunction

   function automatic walk_rsp_type table_walk(input logic [63:0] page);
      walk_rsp_type r;
      logic [63:0] leaf, k1, k2, k3;
      int l;
      bit ok;
      r = '0;
      l = levels_in_use();
      if (!page_in_range(page)) begin
         r.range_error = 1'b1;
         return r;
      end
      split_index(page - 64'd1, leaf, k1, k2, k3);
      ok = 1'b1;
      if (l >= 2 && !top_valid[k1[11:0]]) ok = 1'b0;
      if (l >= 3 && !second_valid[k2[11:0]]) ok = 1'b0;
      if (l == 4 && !third_valid[k3[11:0]]) ok = 1'b0;
      if (!ok) return r;
      r.path_valid   = 1'b1;
      r.page_mapped  = leaf_mapped[leaf[11:0]];
      r.entry_in_ram = leaf_in_ram[leaf[11:0]];
      r.entry_frame  = leaf_frames[leaf[11:0]];
      r.fault        = !leaf_in_ram[leaf[11:0]];
      return r;
   endfunction

   // update the local table for one accepted beat and give the result it should cause
   function automatic walk_rsp_type apply_request(input walk_req_type beat);
      logic [63:0] page;
      logic [63:0] leaf, k1, k2, k3;
      int l;
      page = {51'd0, beat.page};
      l = levels_in_use();
      case (beat.operation)
         OP_MAP: begin
            if (page_in_range(page)) begin
               split_index(page - 64'd1, leaf, k1, k2, k3);
               leaf_frames[leaf[11:0]] = beat.frame;
               leaf_in_ram[leaf[11:0]] = beat.in_ram;
               leaf_mapped[leaf[11:0]] = 1'b1;
               if (l >= 2) top_valid[k1[11:0]] = 1'b1;
               if (l >= 3) second_valid[k2[11:0]] = 1'b1;
               if (l == 4) third_valid[k3[11:0]] = 1'b1;
            end
            return table_walk(page);
         end
         OP_ACCESS: return table_walk(({16'd0, beat.vaddr} >> cfg_page_shift) + 64'd1);
         OP_LOOKUP: return table_walk(page);
         default:   return '0;
      endcase
   endfunction

   function automatic void queue_request(input logic [OP_W-1:0] op, input logic [VA_W-1:0] va,
                                         input logic [PAGE_W-1:0] page,
                                         input logic [FRAME_W-1:0] frame, input logic ram);
      walk_req_type it;
      it.operation = op;
      it.vaddr     = va;
      it.page      = page;
      it.frame     = frame;
      it.in_ram    = ram;
      pending_reqs = {pending_reqs, it};
   endfunction

   // mostly pages already touched in this phase, so walks find valid paths
   function automatic logic [PAGE_W-1:0] choose_page(input int lim);
      int sel;
      logic [PAGE_W-1:0] p;
      sel = $urandom_range(0, 9);
      if (hot_pages.size() > 0 && sel < 6)
         return hot_pages[$urandom_range(0, hot_pages.size() - 1)];
      if (hot_pages.size() > 0 && sel == 6)
         return hot_pages[$urandom_range(0, hot_pages.size() - 1)] + PAGE_W'($urandom_range(0, 3));
      if (lim > 0 && sel < 8) begin
         p = PAGE_W'($urandom_range(1, lim));
         hot_pages = {hot_pages, p};
         if (hot_pages.size() > 12) void'(hot_pages.pop_front());
         return p;
      end
      if (sel == 8) begin
         case ($urandom_range(0, 2))
            0:       return '0;
            1:       return PAGE_W'(lim);
            default: return PAGE_W'(lim + 1);
         endcase
      end
      return PAGE_W'($urandom);
   endfunction

   function automatic void queue_random_requests(input int count);
      walk_req_type it;
      int pick;
      int lim;
      logic [63:0] offset;
      logic [PAGE_W-1:0] page;
      lim = page_limit();
      repeat (count) begin
         it.vaddr  = VA_W'({$urandom(), $urandom()});
         it.page   = PAGE_W'($urandom);
         it.frame  = FRAME_W'({$urandom(), $urandom()});
         it.in_ram = $urandom_range(0, 1);
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            it.operation = OP_MAP;
            it.page      = choose_page(lim);
         end else if (pick < 65) begin
            it.operation = OP_LOOKUP;
            it.page      = choose_page(lim);
         end else if (pick < 95) begin
            it.operation = OP_ACCESS;
            // three times in four, an address inside a chosen page with a random byte offset
            if ($urandom_range(0, 3) != 0) begin
               page   = choose_page(lim);
               offset = {$urandom(), $urandom()} & ((64'd1 << cfg_page_shift) - 64'd1);
               it.vaddr = VA_W'((({51'd0, page} - 64'd1) << cfg_page_shift) | offset);
            end
         end else begin
            it.operation = OP_RESERVED;
         end
         pending_reqs = {pending_reqs, it};
      end
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_PAGE_SHIFT:  cfg_page_shift  = data[SHIFT_W-1:0];
         CSR_LEVEL_BITS:  cfg_level_bits  = data[LBITS_W-1:0];
         CSR_LEVEL_COUNT: cfg_level_count = data[LCOUNT_W-1:0];
         default:         cfg_page_count  = data[PAGE_W-1:0];
      endcase
   endtask

   // wait until nothing is queued, offered or outstanding, then let the block settle
   task automatic wait_for_drain();
      while (pending_reqs.size() != 0 || req_valid || expected_walks.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // new geometry then random beats; all but page count get junk upper bits on purpose
   task automatic run_phase(input int shift, input int bits, input int levels,
                            input int pages, input int count);
      wait_for_drain();
      write_csr(CSR_PAGE_SHIFT, CSR_DATA_W'(shift | ($urandom << SHIFT_W)));
      write_csr(CSR_LEVEL_BITS, CSR_DATA_W'(bits | ($urandom << LBITS_W)));
      write_csr(CSR_LEVEL_COUNT, CSR_DATA_W'(levels | ($urandom << LCOUNT_W)));
      write_csr(CSR_PAGE_COUNT, CSR_DATA_W'(pages));
      req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      hot_pages.delete();
      queue_random_requests(count);
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // request driver: offers queued beats, predicts each one as it is taken
   always @(posedge clock) begin : request_driver
      logic taken;
      taken = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
         req_wait_left = 0;
      end else begin
         if (taken) expected_walks = {expected_walks, apply_request(offered_beat)};
         if (!req_valid || taken) begin
            if (req_wait_left > 0 || pending_reqs.size() == 0) begin
               if (req_wait_left > 0) req_wait_left--;
               req_valid <= 1'b0;
            end else begin
               offered_beat = pending_reqs.pop_front();
               req_operation <= offered_beat.operation;
               req_vaddr     <= offered_beat.vaddr;
               req_page      <= offered_beat.page;
               req_frame     <= offered_beat.frame;
               req_in_ram    <= offered_beat.in_ram;
               req_valid     <= 1'b1;
               req_wait_left = $urandom_range(0, req_gap_max);
            end
         end
      end
   end

   // response monitor: checks each beat, stalls at random, now and then holds off for long
   always @(posedge clock) begin : response_monitor
      walk_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_walks.size() == 0) begin
               $error("result beat with nothing outstanding");
               mismatches++;
            end else begin
               want = expected_walks.pop_front();
               compare_field("range_error", 64'(want.range_error), 64'(rsp_range_error));
               compare_field("path_valid", 64'(want.path_valid), 64'(rsp_path_valid));
               compare_field("page_mapped", 64'(want.page_mapped), 64'(rsp_page_mapped));
               compare_field("entry_in_ram", 64'(want.entry_in_ram), 64'(rsp_entry_in_ram));
               compare_field("entry_frame", 64'(want.entry_frame), 64'(rsp_entry_frame));
               compare_field("fault", 64'(want.fault), 64'(rsp_fault));
            end
            results_seen++;
            rsp_wait_left = $urandom_range(0, rsp_gap_max);
            if (results_seen % 150 == 100) rsp_hold_left = $urandom_range(150, 250);
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait_left > 0) begin
            rsp_wait_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: too long without any beat moving on either side
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[radix_page_table_map_and_walk] ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed beats at the reset geometry: 4 KiB pages, two levels of 9 bits
      queue_request(OP_LOOKUP, '0, 13'd0, '0, 1'b0);            // page zero
      queue_request(OP_LOOKUP, '0, 13'd4096, '0, 1'b0);         // last page, path not valid
      queue_request(OP_MAP, '0, 13'd1, '1, 1'b1);               // widest frame
      queue_request(OP_LOOKUP, '0, 13'd1, '0, 1'b0);
      queue_request(OP_ACCESS, '0, '0, '0, 1'b0);               // address zero is page one
      queue_request(OP_ACCESS, 48'h0000_00FF_FFFF, '0, '0, 1'b0);
      queue_request(OP_MAP, '1, 13'd4096, '0, 1'b0);            // swapped-out last page
      queue_request(OP_ACCESS, 48'h0000_00FF_FFFF, '0, '1, 1'b1);
      queue_request(OP_LOOKUP, '0, 13'd4095, '0, 1'b0);         // valid path, unmapped leaf
      queue_request(OP_MAP, '0, 13'd0, 36'h1_2345_6789, 1'b1);  // map out of range
      queue_request(OP_MAP, '0, 13'd4097, 36'hF_0F0F_0F0F, 1'b1);
      queue_request(OP_MAP, '1, 13'h1FFF, '1, 1'b1);
      queue_request(OP_LOOKUP, '1, 13'h1FFF, '1, 1'b1);
      queue_request(OP_ACCESS, '1, '0, '0, 1'b0);               // huge page number
      queue_request(OP_RESERVED, '1, '1, '1, 1'b1);
      queue_request(OP_RESERVED, '0, '0, '0, 1'b0);
      queue_request(OP_MAP, '0, 13'd513, 36'h5_A5A5_A5A5, 1'b1); // second top entry
      queue_request(OP_LOOKUP, '0, 13'd513, '0, 1'b0);
      queue_request(OP_MAP, '0, 13'd1, 36'h0_0000_0001, 1'b0);  // overwrite a mapped page
      queue_request(OP_LOOKUP, '0, 13'd1, '0, 1'b0);
      queue_request(OP_ACCESS, 48'h0000_0000_0FFF, '0, '0, 1'b0);
      queue_request(OP_LOOKUP, '0, 13'd2, '0, 1'b0);

      // fixed geometries, extremes included, then random ones
      run_phase(12, 3, 4, 4096, 55);
      run_phase(0, 1, 1, 64, 50);
      run_phase(31, 12, 4, 8191, 50);
      run_phase(4, 0, 7, 4096, 50);
      run_phase(30, 15, 0, 100, 50);
      run_phase(8, 4, 3, 0, 20);
      run_phase(10, 6, 2, 4096, 55);
      run_phase(12, 2, 3, 300, 55);
      repeat (4)
         run_phase($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 7),
                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                               : $urandom_range(1, 4096), 55);

      wait_for_drain();
      if (mismatches == 0 && expected_walks.size() == 0)
         $display("[radix_page_table_map_and_walk] OK");
      else
         $display("[radix_page_table_map_and_walk] ERROR");
      $finish;
   end

endmodule

### sim.f
src/rptw_pkg.sv
src/rptw_ctrl.sv
src/rptw_datapath.sv
src/radix_page_table_map_and_walk.sv
tb/tb_radix_page_table_map_and_walk.sv
